// ===== hw/rtl/prq_pkg.sv =====
package prq_pkg;

    localparam int TASK_W  = 4;
    localparam int PRI_W   = 8;
    localparam int PER_W   = 16;
    localparam int LEVEL_W = 5;

    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_DEQUEUE = 1'b1;

    typedef struct packed {
        logic              func;
        logic [TASK_W-1:0] task_id;
        logic [PRI_W-1:0]  priority_req;
        logic [PER_W-1:0]  period;
    } req_t;

    typedef struct packed {
        logic [TASK_W-1:0]  out_task_id;
        logic               out_valid;
        logic               dup_error;
        logic [LEVEL_W-1:0] queue_level;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// ===== hw/rtl/prq_if.sv =====
interface prq_req_if
    import prq_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prq_rsp_if
    import prq_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/prq_ctrl.sv =====
module prq_ctrl
    import prq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    always_comb
    begin
        out_free       = !rsp_valid_reg || rsp_ready;
        req_ready      = (state_reg == S_IDLE);
        cmd.load       = req_ready && req_valid;
        cmd.exec       = (state_reg == S_EXEC) && out_free;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold the request until the output register is free
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== hw/rtl/prq_datapath.sv =====
module prq_datapath
    import prq_pkg::*;
#(
    parameter int MAX_TASKS     = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PERIOD_BITS   = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  req_t req_data,
    output rsp_t rsp_data
);

    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int NUM_FLAGS = (MAX_TASKS < (1 << TASK_W)) ? MAX_TASKS : (1 << TASK_W);
    localparam int FLAG_W    = $clog2(NUM_FLAGS);

    req_t req_reg;
    rsp_t rsp_reg, rsp_next;

    logic [TASK_W-1:0]        task_reg [MAX_TASKS];
    logic [PRIORITY_BITS-1:0] pri_reg  [MAX_TASKS];
    logic [PERIOD_BITS-1:0]   per_reg  [MAX_TASKS];
    logic [TASK_W-1:0]        task_next [MAX_TASKS];
    logic [PRIORITY_BITS-1:0] pri_next  [MAX_TASKS];
    logic [PERIOD_BITS-1:0]   per_next  [MAX_TASKS];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [NUM_FLAGS-1:0]     flag_reg, flag_next;

    logic [PRIORITY_BITS-1:0] new_pri;
    logic [PERIOD_BITS-1:0]   new_per;
    logic [31:0]              tid_ext, head_ext, level_ext;
    logic [FLAG_W-1:0]        tid_idx, head_idx;
    logic                     tid_ok, is_dup, is_enq, do_insert, do_pop;
    logic [MAX_TASKS-1:0]     keep;

    always_comb
    begin
        new_pri   = PRIORITY_BITS'(req_reg.priority_req);
        new_per   = PERIOD_BITS'(req_reg.period);
        tid_ext   = 32'(req_reg.task_id);
        tid_ok    = tid_ext < 32'(MAX_TASKS);
        tid_idx   = tid_ext[FLAG_W-1:0];
        is_dup    = tid_ok && flag_reg[tid_idx];
        is_enq    = (req_reg.func == FUNC_ENQUEUE);
        do_insert = is_enq && tid_ok && !is_dup && (count_reg < CNT_W'(MAX_TASKS));
        do_pop    = (req_reg.func == FUNC_DEQUEUE) && (count_reg != '0);
        head_ext  = 32'(task_reg[0]);
        head_idx  = head_ext[FLAG_W-1:0];

        // new entry goes behind every live entry that is not strictly worse
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            keep[k] = (CNT_W'(k) < count_reg)
                && !((new_pri < pri_reg[k])
                     || ((new_pri == pri_reg[k]) && (new_per < per_reg[k])));
        end

        task_next  = task_reg;
        pri_next   = pri_reg;
        per_next   = per_reg;
        count_next = count_reg;
        flag_next  = flag_reg;

        if (do_insert)
        begin
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                if (!keep[k])
                begin
                    if (k == 0 || keep[(k == 0) ? 0 : k - 1])
                    begin
                        task_next[k] = req_reg.task_id;
                        pri_next[k]  = new_pri;
                        per_next[k]  = new_per;
                    end
                    else
                    begin
                        task_next[k] = task_reg[(k == 0) ? 0 : k - 1];
                        pri_next[k]  = pri_reg[(k == 0) ? 0 : k - 1];
                        per_next[k]  = per_reg[(k == 0) ? 0 : k - 1];
                    end
                end
            end
            count_next        = count_reg + 1'b1;
            flag_next[tid_idx] = 1'b1;
        end
        else if (do_pop)
        begin
            // advance every entry one slot toward the head
            for (int k = 0; k < MAX_TASKS - 1; k++)
            begin
                task_next[k] = task_reg[k + 1];
                pri_next[k]  = pri_reg[k + 1];
                per_next[k]  = per_reg[k + 1];
            end
            count_next = count_reg - 1'b1;
            if (head_ext < 32'(MAX_TASKS))
            begin
                flag_next[head_idx] = 1'b0;
            end
        end

        level_ext            = 32'(count_next);
        rsp_next.out_task_id = do_pop ? task_reg[0] : '0;
        rsp_next.out_valid   = do_pop;
        rsp_next.dup_error   = is_enq && is_dup;
        rsp_next.queue_level = level_ext[LEVEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_data;
        end
        if (cmd.exec)
        begin
            rsp_reg  <= rsp_next;
            task_reg <= task_next;
            pri_reg  <= pri_next;
            per_reg  <= per_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

// ===== hw/rtl/priority_ready_queue_core.sv =====
// Sorted task ready queue, shift-register cells with parallel slot compare.
// A request is taken into the request register, then compared and shifted over all
// cells at once, and the result goes to the response register. No new request is
// accepted until the current one has executed, which waits on a stalled response side.
// Reset: asynchronous, clears entry count, queued flags and handshake state;
// entry cells are not cleared and are never read before written.
module priority_ready_queue_core
    import prq_pkg::*;
#(
    parameter int MAX_TASKS     = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PERIOD_BITS   = 16
)
(
    input logic      clk,
    input logic      rst_n,
    prq_req_if.sink  req,
    prq_rsp_if.source rsp
);

    cmd_t cmd;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp_data;

    prq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    prq_datapath #(
        .MAX_TASKS     (MAX_TASKS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PERIOD_BITS   (PERIOD_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req.data),
        .rsp_data (rsp_data)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

endmodule
